@@ hdl/mlfd_pkg.sv @@
// shared types and constants for the magic/length frame deframer
// no dependencies; every other file of the block imports this package

package mlfd_pkg;

  localparam int ByteW     = 8;
  localparam int WordW     = 32;
  localparam int KindW     = 2;
  localparam int HdrBytes  = 12;
  localparam int FillW     = 4;
  localparam int CfgIndexW = 1;

  localparam int QueueDepthDefault = 2;

  localparam logic [WordW-1:0] MagicReset  = 32'h0000_0000;
  localparam logic [WordW-1:0] MaxLenReset = 32'h0001_0000;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_MAGIC_WORD = 1'b0,
    CFG_MAX_LEN    = 1'b1
  } cfg_index_t;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KIND_BODY     = 2'd0,
    KIND_OVERSIZE = 2'd1,
    KIND_EMPTY    = 2'd2
  } kind_t;

  // one result item as it travels from front to back
  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] body_byte;
    logic [WordW-1:0] frame_request_id;
    logic [WordW-1:0] frame_length;
    logic             first_of_frame;
    logic             last_of_frame;
  } result_t;

endpackage

@@ hdl/mlfd_if.sv @@
// valid/ready channel interfaces for the received byte and result streams
// depends on mlfd_pkg for field widths

interface mlfd_in_if;
  import mlfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlfd_out_if;
  import mlfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] body_byte;
  logic [WordW-1:0] frame_request_id;
  logic [WordW-1:0] frame_length;
  logic             first_of_frame;
  logic             last_of_frame;

  modport source (output valid, output kind, output body_byte, output frame_request_id,
                  output frame_length, output first_of_frame, output last_of_frame,
                  input ready);
  modport sink   (input valid, input kind, input body_byte, input frame_request_id,
                  input frame_length, input first_of_frame, input last_of_frame,
                  output ready);
endinterface

@@ hdl/mlfd_front.sv @@
// front end: takes received bytes, hunts the 12-byte header and tracks the body
// depends on mlfd_pkg; pushes result items into mlfd_queue

module mlfd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mlfd_pkg::ByteW-1:0] rx_byte,
  input  logic [mlfd_pkg::WordW-1:0] magic_word,
  input  logic [mlfd_pkg::WordW-1:0] max_body_length,
  input  logic                       q_full,
  output logic                       push,
  output mlfd_pkg::result_t          push_data
);
  import mlfd_pkg::*;

  logic [ByteW-1:0] window_r [HdrBytes];
  logic [FillW-1:0] fill_r;
  logic             in_body_r;
  logic [WordW-1:0] left_r;
  logic [WordW-1:0] rid_r;
  logic [WordW-1:0] len_r;

  logic             accept;
  logic             hdr_done;
  logic [WordW-1:0] hdr_magic;
  logic [WordW-1:0] hdr_rid;
  logic [WordW-1:0] hdr_len;
  logic             magic_ok;
  logic             oversize;
  logic             len_zero;

  assign in_ready = ~q_full;
  assign accept   = in_valid & ~q_full;

  // header fields as they stand once the incoming byte completes the window
  assign hdr_done  = ~in_body_r && (fill_r == FillW'(HdrBytes - 1));
  assign hdr_magic = {window_r[4], window_r[3], window_r[2], window_r[1]};
  assign hdr_rid   = {window_r[8], window_r[7], window_r[6], window_r[5]};
  assign hdr_len   = {rx_byte, window_r[11], window_r[10], window_r[9]};
  assign magic_ok  = (hdr_magic == magic_word);
  assign oversize  = (hdr_len > max_body_length);
  assign len_zero  = (hdr_len == '0);

  // classify the byte into a result item, if it makes one
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (in_body_r) begin
      push                     = accept;
      push_data.kind           = KIND_BODY;
      push_data.body_byte      = rx_byte;
      push_data.frame_request_id = rid_r;
      push_data.frame_length   = len_r;
      push_data.first_of_frame = (left_r == len_r);
      push_data.last_of_frame  = (left_r == WordW'(1));
    end else if (hdr_done && magic_ok && oversize) begin
      push                       = accept;
      push_data.kind             = KIND_OVERSIZE;
      push_data.frame_request_id = hdr_rid;
      push_data.frame_length     = hdr_len;
    end else if (hdr_done && magic_ok && len_zero) begin
      push                       = accept;
      push_data.kind             = KIND_EMPTY;
      push_data.frame_request_id = hdr_rid;
      push_data.first_of_frame   = 1'b1;
      push_data.last_of_frame    = 1'b1;
    end
  end

  // header window: newest byte enters at the top, oldest falls off the bottom
  always_ff @(posedge clk) begin
    if (accept && ~in_body_r) begin
      for (int i = 0; i < HdrBytes - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[HdrBytes-1] <= rx_byte;
    end
  end

  // hunt / body control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      in_body_r <= 1'b0;
      left_r    <= '0;
      rid_r     <= '0;
      len_r     <= '0;
    end else if (accept) begin
      if (in_body_r) begin
        left_r <= left_r - WordW'(1);
        if (left_r == WordW'(1)) begin
          in_body_r <= 1'b0;
        end
      end else if (!hdr_done) begin
        fill_r <= fill_r + FillW'(1);
      end else if (magic_ok) begin
        // header taken or rejected: window starts over
        fill_r <= '0;
        if (!oversize) begin
          rid_r <= hdr_rid;
          len_r <= hdr_len;
          if (!len_zero) begin
            in_body_r <= 1'b1;
            left_r    <= hdr_len;
          end
        end
      end
      // magic mismatch: the shift dropped the oldest byte, fill stays at eleven
    end
  end

endmodule

@@ hdl/mlfd_queue.sv @@
// small result queue between the front end and the output stage
// depends on mlfd_pkg for the result item type

module mlfd_queue #(
  parameter int QUEUE_DEPTH = mlfd_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mlfd_pkg::result_t push_data,
  output logic              full,
  input  logic              pop,
  output mlfd_pkg::result_t pop_data,
  output logic              not_empty
);
  import mlfd_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  result_t         mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign full      = (count_r == CntW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

@@ hdl/mlfd_back.sv @@
// output stage: moves queued result items into the registered result channel
// depends on mlfd_pkg for the result item type

module mlfd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  mlfd_pkg::result_t          q_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mlfd_pkg::KindW-1:0] out_kind,
  output logic [mlfd_pkg::ByteW-1:0] out_body_byte,
  output logic [mlfd_pkg::WordW-1:0] out_frame_request_id,
  output logic [mlfd_pkg::WordW-1:0] out_frame_length,
  output logic                       out_first_of_frame,
  output logic                       out_last_of_frame
);
  import mlfd_pkg::*;

  logic    valid_r;
  result_t data_r;

  // load whenever the register is empty or its transfer completes
  assign pop = q_valid & (~valid_r | out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (~valid_r | out_ready) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= q_data;
    end
  end

  assign out_valid            = valid_r;
  assign out_kind             = data_r.kind;
  assign out_body_byte        = data_r.body_byte;
  assign out_frame_request_id = data_r.frame_request_id;
  assign out_frame_length     = data_r.frame_length;
  assign out_first_of_frame   = data_r.first_of_frame;
  assign out_last_of_frame    = data_r.last_of_frame;

endmodule

@@ hdl/magic_length_frame_deframer_core.sv @@
// Length-prefixed frame deframer with magic-word resync, top level.
//
// in_chan carries one received stream byte per transfer. The block collects a
// 12-byte little-endian header (magic word, request id, body length). On a
// magic mismatch the oldest byte is dropped and the hunt goes on, with no
// result. An accepted header with a nonzero length passes its body bytes out
// one per transfer on out_chan, tagged with request id, length and first/last
// flags; an empty body gives one empty-frame result, an oversize length one
// error result. cfg_we/cfg_index/cfg_wdata write magic_word (index 0) and
// max_body_length (index 1); write them only while the block is idle.
// Throughput: one byte per cycle while the queue is not full, with the
// header compare in the front end combinational. A result is registered
// into the queue, then into the output register, before it shows on out_chan.
// On an out_chan stall the queue (QUEUE_DEPTH, two by default) and output
// register absorb results; in_chan.ready drops until the receiver takes one.
// Reset (rst_n low, synchronous) empties the window, queue and output stage
// and restores the register defaults (magic 0, max length 65536).
// depends on mlfd_pkg, mlfd_if, mlfd_front, mlfd_queue and mlfd_back

module magic_length_frame_deframer_core #(
  parameter int QUEUE_DEPTH = mlfd_pkg::QueueDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mlfd_in_if.sink                        in_chan,
  mlfd_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [mlfd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [mlfd_pkg::WordW-1:0]     cfg_wdata
);
  import mlfd_pkg::*;

  logic [WordW-1:0] magic_r;
  logic [WordW-1:0] max_len_r;

  logic    q_full;
  logic    q_not_empty;
  logic    push;
  logic    pop;
  result_t push_data;
  result_t pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MagicReset;
      max_len_r <= MaxLenReset;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAGIC_WORD: magic_r   <= cfg_wdata;
        CFG_MAX_LEN:    max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // header hunt and body tracking
  mlfd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .rx_byte         (in_chan.rx_byte),
    .magic_word      (magic_r),
    .max_body_length (max_len_r),
    .q_full          (q_full),
    .push            (push),
    .push_data       (push_data)
  );

  // decoupling queue
  mlfd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty)
  );

  // registered result channel
  mlfd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_not_empty),
    .q_data               (pop_data),
    .pop                  (pop),
    .out_valid            (out_chan.valid),
    .out_ready            (out_chan.ready),
    .out_kind             (out_chan.kind),
    .out_body_byte        (out_chan.body_byte),
    .out_frame_request_id (out_chan.frame_request_id),
    .out_frame_length     (out_chan.frame_length),
    .out_first_of_frame   (out_chan.first_of_frame),
    .out_last_of_frame    (out_chan.last_of_frame)
  );

endmodule

@@ hdl/mlfd_checker.sv @@
// port-level checks on the deframer result channel, bound to the top level
// depends on mlfd_pkg for the result kind codes

module mlfd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mlfd_pkg::KindW-1:0] out_kind,
  input logic [mlfd_pkg::ByteW-1:0] out_body_byte,
  input logic [mlfd_pkg::WordW-1:0] out_frame_length,
  input logic                       out_first_of_frame,
  input logic                       out_last_of_frame
);
  import mlfd_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its kind, body byte and frame length
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_body_byte)
                                && $stable(out_frame_length))
    else $error("result changed while stalled");

  // empty frame is a whole frame with no data and zero length
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EMPTY |->
      out_first_of_frame && out_last_of_frame && out_body_byte == '0
      && out_frame_length == '0)
    else $error("bad empty-frame result");

  // oversize error carries no frame flags and a length that is not zero
  a_oversize: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_OVERSIZE |->
      !out_first_of_frame && !out_last_of_frame && out_frame_length != '0)
    else $error("bad oversize result");

  // body bytes only ever belong to a nonempty frame
  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BODY |-> out_frame_length != '0)
    else $error("body byte of an empty frame");

endmodule

bind magic_length_frame_deframer_core mlfd_checker u_mlfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_kind           (out_chan.kind),
  .out_body_byte      (out_chan.body_byte),
  .out_frame_length   (out_chan.frame_length),
  .out_first_of_frame (out_chan.first_of_frame),
  .out_last_of_frame  (out_chan.last_of_frame)
);

@@ bench/magic_length_frame_deframer_core_test.sv @@
// self-checking bench for magic_length_frame_deframer_core: byte stream in,
// deframed results out, with a byte-level predictor of the header hunt
// depends on mlfd_pkg, mlfd_if and the core's sources
`timescale 1ns / 1ps

module magic_length_frame_deframer_core_test;
  import mlfd_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomItems  = 700;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxPrinted   = 40;
  localparam int unsigned IdlePercent  = 22;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [WordW-1:0]     cfg_wdata;

  mlfd_in_if  in_if ();
  mlfd_out_if out_if ();

  magic_length_frame_deframer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state: register copies and the header window
  logic [WordW-1:0] reg_magic;
  logic [WordW-1:0] reg_max_len;
  logic [ByteW-1:0] win_bytes [HdrBytes];
  int unsigned      win_fill;
  logic             body_active;
  logic [WordW-1:0] body_left;
  logic [WordW-1:0] body_rid;
  logic [WordW-1:0] body_len;

  result_t     pending_results [$];
  int unsigned mismatches;
  int unsigned random_sent;
  int unsigned cycle_count;
  logic        steady;
  int unsigned hold_ticket;
  int unsigned hold_served;
  int unsigned hold_left;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    if (mismatches < MaxPrinted)
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [WordW-1:0] got,
                             input logic [WordW-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // expected results for one accepted stream byte
  function automatic void predict_deframe(input logic [ByteW-1:0] b);
    result_t          r;
    logic [WordW-1:0] magic;
    logic [WordW-1:0] rid;
    logic [WordW-1:0] len;
    r = '0;
    if (body_active) begin
      r.kind             = KIND_BODY;
      r.body_byte        = b;
      r.frame_request_id = body_rid;
      r.frame_length     = body_len;
      r.first_of_frame   = (body_left == body_len);
      r.last_of_frame    = (body_left == 1);
      pending_results.push_back(r);
      body_left = body_left - 1;
      if (body_left == 0) body_active = 1'b0;
      return;
    end
    win_bytes[win_fill] = b;
    win_fill++;
    if (win_fill < HdrBytes) return;
    magic = {win_bytes[3], win_bytes[2], win_bytes[1], win_bytes[0]};
    rid   = {win_bytes[7], win_bytes[6], win_bytes[5], win_bytes[4]};
    len   = {win_bytes[11], win_bytes[10], win_bytes[9], win_bytes[8]};
    // magic miss: slide the window by one byte
    if (magic != reg_magic) begin
      for (int i = 0; i < HdrBytes - 1; i++) win_bytes[i] = win_bytes[i + 1];
      win_bytes[HdrBytes - 1] = '0;
      win_fill = HdrBytes - 1;
      return;
    end
    win_fill           = 0;
    r.frame_request_id = rid;
    r.frame_length     = len;
    if (len > reg_max_len) begin
      r.kind = KIND_OVERSIZE;
      pending_results.push_back(r);
      return;
    end
    body_rid = rid;
    body_len = len;
    if (len == 0) begin
      r.kind           = KIND_EMPTY;
      r.first_of_frame = 1'b1;
      r.last_of_frame  = 1'b1;
      pending_results.push_back(r);
      return;
    end
    body_left   = len;
    body_active = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {kind_t'(out_if.kind), out_if.body_byte, out_if.frame_request_id,
             out_if.frame_length, out_if.first_of_frame, out_if.last_of_frame};
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, kind", got.kind, '0);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("body_byte", got.body_byte, want.body_byte);
        check_field("frame_request_id", got.frame_request_id, want.frame_request_id);
        check_field("frame_length", got.frame_length, want.frame_length);
        check_field("first_of_frame", got.first_of_frame, want.first_of_frame);
        check_field("last_of_frame", got.last_of_frame, want.last_of_frame);
      end
    end
  end

  // receiver ready: random stalls, long hold-offs on request
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served  <= hold_ticket;
      hold_left    <= HoldCycles;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(99) >= IdlePercent);
    end
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (!steady) begin
      while ($urandom_range(99) < IdlePercent) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    predict_deframe(b);
    random_sent++;
  endtask

  // header bytes, little-endian; count below 12 gives a truncated header
  task automatic send_header(input logic [WordW-1:0] magic, input logic [WordW-1:0] rid,
                             input logic [WordW-1:0] len, input int unsigned count);
    logic [3*WordW-1:0] hdr;
    hdr = {len, rid, magic};
    for (int i = 0; i < count; i++) send_byte(hdr[8*i +: 8]);
  endtask

  task automatic send_noise(input int unsigned count);
    for (int i = 0; i < count; i++) send_byte(8'($urandom_range(255)));
  endtask

  // header with the current magic, then a body if the length fits
  task automatic send_frame(input logic [WordW-1:0] rid, input logic [WordW-1:0] len);
    send_header(reg_magic, rid, len, HdrBytes);
    if (len <= reg_max_len) send_noise(len);
  endtask

  // sender pause until every expected result is back
  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // write both registers; block must be idle
  task automatic load_config(input logic [WordW-1:0] magic, input logic [WordW-1:0] max_len);
    wait_results_done();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAGIC_WORD;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= CFG_MAX_LEN;
    cfg_wdata <= max_len;
    @(posedge clk);
    cfg_we      <= 1'b0;
    reg_magic   = magic;
    reg_max_len = max_len;
  endtask

  // reset register values: all-zero header gives an empty frame, then a one-byte body
  task automatic test_reset_defaults();
    send_header(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, HdrBytes);
    send_header(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, HdrBytes);
    send_byte(8'hFF);
    wait_results_done();
  endtask

  // register extremes, oversize and empty frames, length at the limit
  task automatic test_register_extremes();
    load_config(32'hFFFF_FFFF, 32'h0000_0000);
    send_frame(32'hA5A5_A5A5, 32'h0000_0001);
    send_frame(32'h5A5A_5A5A, 32'h0000_0000);
    load_config(32'h0000_0000, 32'hFFFF_FFFE);
    send_frame(32'h0000_0001, 32'hFFFF_FFFF);
    load_config(32'hA55A_C33C, 32'hFFFF_FFFF);
    send_header(reg_magic, 32'h1234_5678, 32'h0000_0003, HdrBytes);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    load_config(32'h3CC3_5AA5, 32'h0000_0004);
    send_frame(32'h0F0F_F0F0, 32'h0000_0004);
    send_frame(32'hF0F0_0F0F, 32'h0000_0005);
    wait_results_done();
  endtask

  // magic resync: junk bytes and a torn header ahead of good frames
  task automatic test_resync();
    load_config(32'hC0FF_EE11, 32'h0000_0010);
    send_noise(5);
    send_frame(32'h0000_00AA, 32'h0000_0002);
    send_header(reg_magic, 32'h0000_00BB, 32'h0000_0001, 2);
    send_frame(32'h0000_00CC, 32'h0000_0001);
    send_header(reg_magic, 32'h0000_00DD, 32'h0000_0001, 7);
    send_frame(32'h0000_00EE, 32'h0000_0003);
    wait_results_done();
  endtask

  // long receiver hold-off while frames keep coming, so the input stalls
  task automatic test_backpressure();
    load_config($urandom(), 32'h0000_0040);
    for (int round = 0; round < 2; round++) begin
      hold_ticket++;
      for (int f = 0; f < 4; f++) send_frame($urandom(), 32'd20);
      wait_results_done();
    end
  endtask

  // random phases: mostly good frames, plus oversize, noise and torn headers
  task automatic test_random_stream();
    int unsigned      phase;
    int unsigned      phase_end;
    int unsigned      pick;
    logic [WordW-1:0] len;
    logic [WordW-1:0] magic;
    logic [WordW-1:0] max_len;
    phase       = 0;
    random_sent = 0;
    while (random_sent < RandomItems) begin
      pick  = $urandom_range(9);
      magic = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
      max_len = ($urandom_range(4) == 0) ? 32'd255 : 32'($urandom_range(0, 40));
      load_config(magic, max_len);
      steady    = (phase == 2);
      phase_end = random_sent + $urandom_range(80, 160);
      while (random_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          case ($urandom_range(9))
            0:       len = 0;
            1:       len = reg_max_len;
            default: len = $urandom_range(0, (reg_max_len < 12) ? reg_max_len : 12);
          endcase
          send_frame($urandom(), len);
        end else if (pick < 80) begin
          len = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF
                                         : reg_max_len + 1 + $urandom_range(0, 3);
          send_frame($urandom(), len);
        end else if (pick < 90) begin
          send_noise($urandom_range(1, 6));
        end else begin
          send_header(reg_magic, $urandom(), $urandom_range(0, 8), $urandom_range(1, 11));
        end
      end
      steady = 1'b0;
      phase++;
    end
    wait_results_done();
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MAGIC_WORD;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready = 1'b0;
    steady       = 1'b0;
    hold_ticket  = 0;
    hold_served  = 0;
    hold_left    = 0;
    cycle_count  = 0;
    mismatches   = 0;
    random_sent  = 0;
    // predictor at its reset values
    reg_magic    = MagicReset;
    reg_max_len  = MaxLenReset;
    win_fill     = 0;
    body_active  = 1'b0;
    body_left    = '0;
    body_rid     = '0;
    body_len     = '0;
    foreach (win_bytes[i]) win_bytes[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_resync();
    test_backpressure();
    test_random_stream();

    wait_results_done();
    if (pending_results.size() != 0)
      report_mismatch("results never arrived, count", pending_results.size(), '0);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mlfd_pkg.sv
hdl/mlfd_if.sv
hdl/mlfd_front.sv
hdl/mlfd_queue.sv
hdl/mlfd_back.sv
hdl/magic_length_frame_deframer_core.sv
hdl/mlfd_checker.sv
bench/magic_length_frame_deframer_core_test.sv
